>>> design/hamming_k_mismatch_search_core_macros.svh
// assertion macros used by the checker of the hamming search core
`ifndef HAMMING_K_MISMATCH_SEARCH_CORE_MACROS_SVH
`define HAMMING_K_MISMATCH_SEARCH_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define HKMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define HKMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/hkms_pkg.sv
// shared constants and types of the hamming k-mismatch search core
`timescale 1ns / 1ps

package hkms_pkg;

  localparam int MAX_PATTERN_DEF   = 32;
  localparam int POSITION_BITS_DEF = 24;
  localparam int POS_W             = 24;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int LEN_CFG_W         = 6;
  localparam int MIS_CFG_W         = 5;
  localparam int NUM_WORDS         = 4;
  localparam int CHARS_PER_WORD    = 8;
  localparam int REG_CHARS         = NUM_WORDS * CHARS_PER_WORD;
  localparam int GROUP             = 8;
  localparam int GROUP_W           = 4;

  localparam logic ACT_CHAR     = 1'b0;
  localparam logic ACT_EOT      = 1'b1;
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH,
    REG_MAX_MISMATCHES,
    REG_PATTERN_WORD_0,
    REG_PATTERN_WORD_1,
    REG_PATTERN_WORD_2,
    REG_PATTERN_WORD_3
  } hkms_reg_e;

  // per-cycle control fanned out to every window cell
  typedef struct packed {
    logic shift;
    logic clear;
    logic load;
  } hkms_cell_ctl_t;

endpackage

>>> design/hkms_cell.sv
// one window cell: holds a text byte, its aligned pattern byte and a mismatch flag
`timescale 1ns / 1ps

module hkms_cell #(
  parameter int MAX_PATTERN = hkms_pkg::MAX_PATTERN_DEF,
  parameter int CELL_IDX    = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  hkms_pkg::hkms_cell_ctl_t           ctl_i,
  input  logic [7:0]                         char_i,
  input  logic [MAX_PATTERN-1:0][7:0]        pattern_i,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]   len_i,
  output logic [7:0]                         char_o,
  output logic                               mis_o
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = $clog2(MAX_PATTERN);

  logic [7:0]       char_q;
  logic [7:0]       pat_q;
  logic             active_q;
  logic             mis_q;
  logic [IDX_W-1:0] sel;

  // pattern byte that lines up with this cell for the current length
  assign sel = IDX_W'(len_i - LEN_W'(1) - LEN_W'(CELL_IDX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= '0;
    end else if (ctl_i.clear) begin
      char_q <= '0;
    end else if (ctl_i.shift) begin
      char_q <= char_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q    <= pattern_i[sel];
    active_q <= (LEN_W'(CELL_IDX) < len_i);
    if (ctl_i.load) begin
      mis_q <= active_q && (char_q != pat_q);
    end
  end

  assign char_o = char_q;
  assign mis_o  = mis_q;

endmodule

>>> design/hkms_mis_tree.sv
// registered mismatch count: group sums of eight cells, then the group total
`timescale 1ns / 1ps

module hkms_mis_tree #(
  parameter int MAX_PATTERN = hkms_pkg::MAX_PATTERN_DEF
) (
  input  logic                              clk_i,
  input  logic                              load_i,
  input  logic [MAX_PATTERN-1:0]            mis_i,
  output logic [$clog2(MAX_PATTERN+1)-1:0]  total_o
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int NG    = (MAX_PATTERN + hkms_pkg::GROUP - 1) / hkms_pkg::GROUP;

  logic [NG-1:0][hkms_pkg::GROUP_W-1:0] grp_d;
  logic [NG-1:0][hkms_pkg::GROUP_W-1:0] grp_q;

  always_comb begin
    grp_d = '0;
    for (int g = 0; g < NG; g++) begin
      for (int k = 0; k < hkms_pkg::GROUP; k++) begin
        if (g * hkms_pkg::GROUP + k < MAX_PATTERN) begin
          grp_d[g] = grp_d[g] + hkms_pkg::GROUP_W'(mis_i[g * hkms_pkg::GROUP + k]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_d;
    end
  end

  always_comb begin
    total_o = '0;
    for (int g = 0; g < NG; g++) begin
      total_o = total_o + LEN_W'(grp_q[g]);
    end
  end

endmodule

>>> design/hamming_k_mismatch_search_core.sv
// top level of the hamming k-mismatch pattern search core
//
//  channel   handshake               payload
//  input     in_valid_i / in_stall_o  action_i, text_char_i
//  output    out_valid_o / out_stall_i kind_o, position_o, none_found_o
//  config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one beat in per cycle unless stalled; characters shift the cell row until the
// position count overflows; a result passes cells, group sums, output register
// a stalled output backs up through the three stages before the input stalls
// no clearing pass after reset; the window comes up zero at once
`timescale 1ns / 1ps

module hamming_k_mismatch_search_core #(
  parameter int MAX_PATTERN   = hkms_pkg::MAX_PATTERN_DEF,
  parameter int POSITION_BITS = hkms_pkg::POSITION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            action_i,
  input  logic [7:0]                      text_char_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            kind_o,
  output logic [hkms_pkg::POS_W-1:0]      position_o,
  output logic                            none_found_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hkms_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hkms_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int CNT_W = POSITION_BITS + 1;
  localparam int EXT_W = 7;
  localparam int CMP_W = (LEN_W > hkms_pkg::MIS_CFG_W) ? LEN_W : hkms_pkg::MIS_CFG_W;

  // configuration registers
  logic [hkms_pkg::LEN_CFG_W-1:0] len_cfg_q;
  logic [hkms_pkg::MIS_CFG_W-1:0] max_mis_q;
  logic [hkms_pkg::NUM_WORDS-1:0][hkms_pkg::CFG_DATA_W-1:0] pat_word_q;

  logic [MAX_PATTERN-1:0][7:0] pat_chars;
  logic [EXT_W-1:0]            len_ext;
  logic [LEN_W-1:0]            len_eff;

  // pipeline control
  logic out_free, c_adv, b_adv, a_adv, acc, is_eot, drop;
  logic a_valid_q, b_valid_q, c_valid_q, out_valid_q;
  logic a_valid_d, b_valid_d, c_valid_d, out_valid_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_next;
  logic any_match_q, any_match_d;

  // payload alongside the stages
  logic a_eot_q, a_chk_q, b_eot_q, b_chk_q, c_eot_q, c_chk_q;
  logic [POSITION_BITS-1:0] a_start_q, b_start_q, c_start_q;
  logic kind_q, none_found_q;
  logic [hkms_pkg::POS_W-1:0] pos_q;

  hkms_pkg::hkms_cell_ctl_t     cell_ctl;
  logic [MAX_PATTERN-1:0][7:0]  win_char;
  logic [MAX_PATTERN-1:0]       mis;
  logic [LEN_W-1:0]             total;
  logic                         hit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q  <= hkms_pkg::LEN_CFG_W'(1);
      max_mis_q  <= hkms_pkg::MIS_CFG_W'(1);
      pat_word_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hkms_pkg::REG_PATTERN_LENGTH: begin
          len_cfg_q <= cfg_data_i[hkms_pkg::LEN_CFG_W-1:0];
        end
        hkms_pkg::REG_MAX_MISMATCHES: begin
          max_mis_q <= cfg_data_i[hkms_pkg::MIS_CFG_W-1:0];
        end
        hkms_pkg::REG_PATTERN_WORD_0: begin
          pat_word_q[0] <= cfg_data_i;
        end
        hkms_pkg::REG_PATTERN_WORD_1: begin
          pat_word_q[1] <= cfg_data_i;
        end
        hkms_pkg::REG_PATTERN_WORD_2: begin
          pat_word_q[2] <= cfg_data_i;
        end
        hkms_pkg::REG_PATTERN_WORD_3: begin
          pat_word_q[3] <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // pattern bytes; those beyond the register words read as zero
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pat
    if (i < hkms_pkg::REG_CHARS) begin : g_reg
      assign pat_chars[i] =
        pat_word_q[i / hkms_pkg::CHARS_PER_WORD][(i % hkms_pkg::CHARS_PER_WORD) * 8 +: 8];
    end else begin : g_zero
      assign pat_chars[i] = '0;
    end
  end

  // length zero acts as one, long lengths saturate at the row size
  always_comb begin
    len_ext = EXT_W'(len_cfg_q);
    if (len_ext == '0) begin
      len_ext = EXT_W'(1);
    end else if (len_ext > EXT_W'(MAX_PATTERN)) begin
      len_ext = EXT_W'(MAX_PATTERN);
    end
    len_eff = LEN_W'(len_ext);
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign c_adv      = !c_valid_q || out_free;
  assign b_adv      = !b_valid_q || c_adv;
  assign a_adv      = !a_valid_q || b_adv;
  assign in_stall_o = !a_adv;

  assign acc      = in_valid_i && a_adv;
  assign is_eot   = (action_i == hkms_pkg::ACT_EOT);
  assign drop     = !is_eot && cnt_q[POSITION_BITS];
  assign cnt_next = cnt_q + CNT_W'(1);

  assign cell_ctl.shift = acc && !is_eot && !drop;
  assign cell_ctl.clear = acc && is_eot;
  assign cell_ctl.load  = b_adv && a_valid_q;

  assign hit = CMP_W'(total) <= CMP_W'(max_mis_q);

  always_comb begin
    a_valid_d   = a_valid_q;
    b_valid_d   = b_valid_q;
    c_valid_d   = c_valid_q;
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    any_match_d = any_match_q;
    if (a_adv) begin
      a_valid_d = acc && !drop;
    end
    if (acc) begin
      if (is_eot) begin
        cnt_d = '0;
      end else if (!drop) begin
        cnt_d = cnt_next;
      end
    end
    if (b_adv) begin
      b_valid_d = a_valid_q;
    end
    if (c_adv) begin
      c_valid_d = b_valid_q;
    end
    if (out_free) begin
      out_valid_d = c_valid_q && (c_eot_q || (c_chk_q && hit));
      if (c_valid_q) begin
        if (c_eot_q) begin
          any_match_d = 1'b0;
        end else if (c_chk_q && hit) begin
          any_match_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      any_match_q <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      b_valid_q   <= b_valid_d;
      c_valid_q   <= c_valid_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      any_match_q <= any_match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_eot_q   <= is_eot;
      a_chk_q   <= (cnt_next >= CNT_W'(len_eff));
      a_start_q <= POSITION_BITS'(cnt_next - CNT_W'(len_eff));
    end
    if (b_adv) begin
      b_eot_q   <= a_eot_q;
      b_chk_q   <= a_chk_q;
      b_start_q <= a_start_q;
    end
    if (c_adv) begin
      c_eot_q   <= b_eot_q;
      c_chk_q   <= b_chk_q;
      c_start_q <= b_start_q;
    end
    if (out_free) begin
      if (c_eot_q) begin
        kind_q       <= hkms_pkg::KIND_SUMMARY;
        pos_q        <= '0;
        none_found_q <= !any_match_q;
      end else begin
        kind_q       <= hkms_pkg::KIND_MATCH;
        pos_q        <= hkms_pkg::POS_W'(c_start_q);
        none_found_q <= 1'b0;
      end
    end
  end

  // row of window cells, newest character in cell zero
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [7:0] char_in;
    if (j == 0) begin : g_head
      assign char_in = text_char_i;
    end else begin : g_link
      assign char_in = win_char[j-1];
    end
    hkms_cell #(
      .MAX_PATTERN (MAX_PATTERN),
      .CELL_IDX    (j)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (cell_ctl),
      .char_i    (char_in),
      .pattern_i (pat_chars),
      .len_i     (len_eff),
      .char_o    (win_char[j]),
      .mis_o     (mis[j])
    );
  end

  hkms_mis_tree #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_tree (
    .clk_i   (clk_i),
    .load_i  (c_adv && b_valid_q),
    .mis_i   (mis),
    .total_o (total)
  );

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign position_o   = pos_q;
  assign none_found_o = none_found_q;

endmodule

>>> design/hkms_checker.sv
// port-level checker of the hamming search core and its bind
`timescale 1ns / 1ps
`include "hamming_k_mismatch_search_core_macros.svh"

module hkms_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            kind_o,
  input logic [hkms_pkg::POS_W-1:0]      position_o,
  input logic                            none_found_o
);

  logic out_beat, match_beat, summary_beat;
  logic seen_match_q;
  logic [hkms_pkg::POS_W-1:0] last_pos_q;

  assign out_beat     = out_valid_o && !out_stall_i;
  assign match_beat   = out_beat && (kind_o == hkms_pkg::KIND_MATCH);
  assign summary_beat = out_beat && (kind_o == hkms_pkg::KIND_SUMMARY);

  // matches seen in the current text, cleared by each summary beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_match_q <= 1'b0;
    end else if (summary_beat) begin
      seen_match_q <= 1'b0;
    end else if (match_beat) begin
      seen_match_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (match_beat) begin
      last_pos_q <= position_o;
    end
  end

  `HKMS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(kind_o) && $stable(position_o) && $stable(none_found_o),
    "stalled result changed or vanished")

  `HKMS_ASSERT_NOW(a_no_false_stall, !out_valid_o || !out_stall_i, !in_stall_o,
    "input stalled while the output side can move")

  `HKMS_ASSERT_NOW(a_summary_flag, summary_beat,
    (none_found_o == !seen_match_q) && (position_o == '0),
    "summary beat disagrees with the matches delivered")

  `HKMS_ASSERT_NOW(a_ascending, match_beat && seen_match_q,
    position_o > last_pos_q,
    "match positions not strictly ascending within a text")

endmodule

bind hamming_k_mismatch_search_core hkms_checker u_hkms_checker (.*);
